/* sv/nlv_pkg.sv */
// ============================================================================
// nlv_pkg - shared types and constants for the number literal validator
// Character codes, recogniser phase and whitespace-run codes, state record.
// ============================================================================
package nlv_pkg;

  localparam int unsigned CharWidth = 8;

  localparam logic [CharWidth-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CharWidth-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CharWidth-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CharWidth-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharWidth-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CharWidth-1:0] CHAR_EXP_U = 8'h45;
  localparam logic [CharWidth-1:0] CHAR_EXP_L = 8'h65;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,   // before the number starts
    PH_MANT = 2'd1,   // mantissa
    PH_EXP  = 2'd2    // exponent
  } nlv_phase_t;

  typedef enum logic [1:0] {
    SR_NONE  = 2'd0,  // no pending whitespace
    SR_BLANK = 2'd1,  // blanks only
    SR_OTHER = 2'd2   // other whitespace, or any after exponent digits
  } nlv_space_t;

  typedef struct packed {
    nlv_phase_t phase;
    logic       dot_seen;
    logic       exp_sign_seen;
    logic       exp_digit_seen;
    logic       failed;
    nlv_space_t space_run;
  } nlv_state_t;

  localparam nlv_state_t ST_CLEAR = '{
    phase:          PH_IDLE,
    dot_seen:       1'b0,
    exp_sign_seen:  1'b0,
    exp_digit_seen: 1'b0,
    failed:         1'b0,
    space_run:      SR_NONE
  };

  function automatic logic is_ws(input logic [CharWidth-1:0] c);
    return (c == CHAR_BLANK) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [CharWidth-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_sign(input logic [CharWidth-1:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS);
  endfunction

  function automatic logic is_exp_letter(input logic [CharWidth-1:0] c);
    return (c == CHAR_EXP_U) || (c == CHAR_EXP_L);
  endfunction

endpackage

/* sv/nlv_ifs.sv */
// ============================================================================
// nlv_ifs - valid/ready channels of the number literal validator
// Character channel in, verdict channel out.
// ============================================================================
interface nlv_in_if;
  logic                          valid;
  logic                          ready;
  logic [nlv_pkg::CharWidth-1:0] char_code;
  logic                          has_char;
  logic                          last_char;

  modport source (output valid, output char_code, output has_char, output last_char,
                  input ready);
  modport sink   (input valid, input char_code, input has_char, input last_char,
                  output ready);
endinterface

interface nlv_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

/* sv/nlv_fsm.sv */
// ============================================================================
// nlv_fsm - recogniser state and per-character update
// Holds the literal state and gives the verdict for a closing character.
// ============================================================================
module nlv_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [nlv_pkg::CharWidth-1:0] char_code,
  input  logic                          has_char,
  input  logic                          last_char,
  output logic                          verdict
);
  import nlv_pkg::*;

  nlv_state_t st_r;
  nlv_state_t st_nxt;
  nlv_state_t upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    upd = st_r;
    if (step && has_char && !st_r.failed) begin
      case (st_r.phase)
        PH_IDLE: begin
          if (is_ws(char_code)) begin
            upd.phase = PH_IDLE;
          end else if (is_sign(char_code) || is_digit(char_code)) begin
            upd.phase = PH_MANT;
          end else if (char_code == CHAR_POINT) begin
            upd.phase    = PH_MANT;
            upd.dot_seen = 1'b1;
          end else begin
            upd.failed = 1'b1;
          end
        end
        PH_MANT: begin
          if (is_ws(char_code)) begin
            upd.space_run = (char_code == CHAR_BLANK && st_r.space_run != SR_OTHER)
                            ? SR_BLANK : SR_OTHER;
          end else if (st_r.space_run == SR_OTHER) begin
            upd.failed = 1'b1;
          end else if (is_exp_letter(char_code)) begin
            upd.phase     = PH_EXP;
            upd.space_run = SR_NONE;
          end else if (st_r.space_run != SR_NONE) begin
            upd.failed = 1'b1;
          end else if (is_digit(char_code)) begin
            upd.phase = PH_MANT;
          end else if (char_code == CHAR_POINT && !st_r.dot_seen) begin
            upd.dot_seen = 1'b1;
          end else begin
            upd.failed = 1'b1;
          end
        end
        PH_EXP: begin
          if (st_r.exp_digit_seen) begin
            if (is_ws(char_code)) begin
              upd.space_run = SR_OTHER;
            end else if (st_r.space_run != SR_NONE || !is_digit(char_code)) begin
              upd.failed = 1'b1;
            end
          end else if (char_code == CHAR_BLANK && !st_r.exp_sign_seen) begin
            upd.phase = PH_EXP;
          end else if (is_digit(char_code)) begin
            upd.exp_digit_seen = 1'b1;
          end else if (is_sign(char_code) && !st_r.exp_sign_seen) begin
            upd.exp_sign_seen = 1'b1;
          end else begin
            upd.failed = 1'b1;
          end
        end
        default: begin
          upd.failed = 1'b1;
        end
      endcase
    end

    case (upd.phase)
      PH_MANT: verdict = !upd.failed;
      PH_EXP:  verdict = !upd.failed && upd.exp_digit_seen;
      default: verdict = 1'b0;
    endcase

    // drop all state once the field's verdict is out
    st_nxt = (step && last_char) ? ST_CLEAR : upd;
  end

  // state is clear after every closing character
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_char) |=> (st_r == ST_CLEAR))
    else $error("state not cleared after closing character");

  a_dot_in_number: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dot_seen |-> (st_r.phase != PH_IDLE))
    else $error("point recorded before the number started");

  a_exp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.exp_sign_seen || st_r.exp_digit_seen) |-> (st_r.phase == PH_EXP))
    else $error("exponent flag set outside the exponent");

  a_blank_run_mantissa: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.space_run == SR_BLANK) |-> (st_r.phase == PH_MANT))
    else $error("blank run pending outside the mantissa");

endmodule

/* sv/number_literal_validator.sv */
// ============================================================================
// number_literal_validator - decimal number literal recogniser
// One character per transaction; one verdict transaction per field.
// ============================================================================
// The closing character passes the input register, then the verdict register.
// Throughput: 1 character per cycle, except that a closing character waits
//   while the verdict register is full; the recogniser state update is a single
//   pass of combinational logic between the input register and the state.
// Reset: synchronous, active low; clears both valid flags and the recogniser
//   state, so the next character starts a fresh field.
module number_literal_validator (
  input  logic      clk,
  input  logic      rst_n,
  nlv_in_if.sink    in_ch,
  nlv_out_if.source out_ch
);
  import nlv_pkg::*;

  // input register
  logic                 in_valid_r;
  logic [CharWidth-1:0] in_char_r;
  logic                 in_has_r;
  logic                 in_last_r;

  // verdict register
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_is_valid_r;

  logic out_free;
  logic s1_advance;
  logic verdict;

  // The verdict register is free if empty or being drained this cycle.
  assign out_free   = !out_valid_r || out_ch.ready;
  // A character that closes no field never waits; a closing one waits for
  // room in the verdict register.
  assign s1_advance = in_valid_r && (!in_last_r || out_free);
  assign in_ch.ready = !in_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // hold the payload while the stage stalls
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_code;
      in_has_r  <= in_ch.has_char;
      in_last_r <= in_ch.last_char;
    end
  end

  // Recogniser state advances once per character leaving the input register.
  nlv_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_advance),
    .char_code (in_char_r),
    .has_char  (in_has_r),
    .last_char (in_last_r),
    .verdict   (verdict)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_advance && in_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the verdict as the closing character leaves the input register
  always_ff @(posedge clk) begin
    if (s1_advance && in_last_r) begin
      out_is_valid_r <= verdict;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_valid = out_is_valid_r;

  // A verdict only appears after a closing character advanced.
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_advance && in_last_r))
    else $error("verdict without a closing character");

  // A closing character never overwrites a verdict still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(s1_advance && in_last_r))
    else $error("pending verdict overwritten");

  // Characters that close no field never stall in the input register.
  a_non_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !in_last_r) |-> s1_advance)
    else $error("non-closing character stalled");

endmodule

/* tb/sv/number_literal_validator_test.sv */
// ============================================================================
// number_literal_validator_test - self-checking bench for the literal recogniser
// Drives text fields one character per transaction. A behavioural predictor
// works out the verdict of every field, and each verdict transaction is checked
// against the oldest prediction. Short directed fields come first, then random
// well-formed numbers, damaged numbers and noise. Both sides idle at random.
// ============================================================================
module number_literal_validator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nlv_pkg::*;

  localparam int unsigned CharTarget = 1300;  // stop random stimulus here
  localparam int unsigned StallLimit = 2000;  // cycles with no transaction at all
  localparam int unsigned SettleCycles = 6;   // settle margin after the last verdict

  // --------------------------------------------------------------------------
  // Verdict predictor: recogniser state plus the queue of verdicts still owed.
  // --------------------------------------------------------------------------
  class verdict_board;
    nlv_phase_t stage;
    logic       point_taken;
    logic       exp_signed;
    logic       exp_digits;
    logic       broken;
    nlv_space_t ws_run;
    logic       verdicts_due[$];
    int         mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      stage       = PH_IDLE;
      point_taken = 1'b0;
      exp_signed  = 1'b0;
      exp_digits  = 1'b0;
      broken      = 1'b0;
      ws_run      = SR_NONE;
    endfunction

    function logic white(logic [CharWidth-1:0] c);
      return c == CHAR_BLANK || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
    endfunction

    function logic numeral(logic [CharWidth-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function logic sign_mark(logic [CharWidth-1:0] c);
      return c == CHAR_PLUS || c == CHAR_MINUS;
    endfunction

    function logic exp_mark(logic [CharWidth-1:0] c);
      return c == CHAR_EXP_U || c == CHAR_EXP_L;
    endfunction

    function void advance(logic [CharWidth-1:0] c);
      if (broken) return;
      case (stage)
        PH_IDLE: begin
          if (white(c)) return;
          if (sign_mark(c) || numeral(c)) stage = PH_MANT;
          else if (c == CHAR_POINT) begin
            stage = PH_MANT;
            point_taken = 1'b1;
          end else broken = 1'b1;
        end
        PH_MANT: begin
          // blanks may sit against the exponent letter or trail; other whitespace only trails
          if (white(c)) ws_run = (c == CHAR_BLANK && ws_run != SR_OTHER) ? SR_BLANK : SR_OTHER;
          else if (ws_run == SR_OTHER) broken = 1'b1;
          else if (exp_mark(c)) begin
            stage  = PH_EXP;
            ws_run = SR_NONE;
          end else if (ws_run != SR_NONE) broken = 1'b1;
          else if (numeral(c)) ;
          else if (c == CHAR_POINT && !point_taken) point_taken = 1'b1;
          else broken = 1'b1;
        end
        PH_EXP: begin
          if (exp_digits) begin
            // after exponent digits any whitespace must be trailing
            if (white(c)) ws_run = SR_OTHER;
            else if (ws_run != SR_NONE || !numeral(c)) broken = 1'b1;
          end else if (c == CHAR_BLANK && !exp_signed) ;
          else if (numeral(c)) exp_digits = 1'b1;
          else if (sign_mark(c) && !exp_signed) exp_signed = 1'b1;
          else broken = 1'b1;
        end
        default: broken = 1'b1;
      endcase
    endfunction

    // note an accepted character transaction
    function void note_char(logic [CharWidth-1:0] code, logic real_char, logic closing);
      if (real_char) advance(code);
      if (closing) begin
        verdicts_due.push_back(!broken &&
                               (stage == PH_MANT || (stage == PH_EXP && exp_digits)));
        restart();
      end
    endfunction

    // check an accepted verdict transaction against the oldest prediction
    function void check_verdict(logic got);
      logic want;
      if (verdicts_due.size() == 0) begin
        $error("is_valid: expected none outstanding, actual %0b", got);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $error("is_valid: expected %0b, actual %0b", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  nlv_in_if  char_ch ();
  nlv_out_if verdict_ch ();

  number_literal_validator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_ch.sink),
    .out_ch (verdict_ch.source)
  );

  verdict_board board = new();

  int unsigned       chars_sent = 0;
  int unsigned       idle_cycles = 0;
  logic              feed_calm = 1'b0;   // sender runs back to back while set
  logic              drain_calm = 1'b0;  // receiver never stalls while set
  logic [CharWidth-1:0] field_text[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves on either side for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("number_literal_validator_test NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Character generators
  // --------------------------------------------------------------------------
  function automatic logic [CharWidth-1:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return CHAR_TAB;
      1:       return CHAR_LF;
      2:       return CHAR_CR;
      default: return CHAR_BLANK;  // blanks matter most around the exponent
    endcase
  endfunction

  function automatic logic [CharWidth-1:0] pick_digit();
    return CHAR_ZERO + CharWidth'($urandom_range(0, 9));
  endfunction

  function automatic logic [CharWidth-1:0] pick_sign();
    return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
  endfunction

  function automatic logic [CharWidth-1:0] pick_exp();
    return $urandom_range(0, 1) ? CHAR_EXP_U : CHAR_EXP_L;
  endfunction

  function automatic logic [CharWidth-1:0] pick_special();
    case ($urandom_range(0, 6))
      0:       return pick_space();
      1:       return pick_sign();
      2:       return CHAR_POINT;
      3:       return pick_exp();
      4:       return pick_digit();
      default: return CharWidth'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one number, usually well-formed, with random content into field_text.
  function automatic void compose_number();
    int unsigned ndig;
    int unsigned pt_at;
    logic        with_point;
    field_text.delete();
    repeat ($urandom_range(0, 2)) field_text.push_back(pick_space());
    if ($urandom_range(0, 2) == 0) field_text.push_back(pick_sign());
    ndig       = $urandom_range(0, 4);
    pt_at      = $urandom_range(0, ndig);
    with_point = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i <= ndig; i++) begin
      if (with_point && i == pt_at) field_text.push_back(CHAR_POINT);
      if (i < ndig) field_text.push_back(pick_digit());
    end
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(0, 2)) field_text.push_back(CHAR_BLANK);
      field_text.push_back(pick_exp());
      repeat ($urandom_range(0, 2)) field_text.push_back(CHAR_BLANK);
      if ($urandom_range(0, 1)) field_text.push_back(pick_sign());
      repeat ($urandom_range(1, 3)) field_text.push_back(pick_digit());
    end
    repeat ($urandom_range(0, 2)) field_text.push_back(pick_space());
  endfunction

  // Mostly well-formed numbers; some damaged by one character; some noise.
  function automatic void compose_field();
    int unsigned kind;
    int unsigned at;
    kind = $urandom_range(0, 9);
    if (kind < 9) begin
      compose_number();
      if (kind >= 6) begin
        at = (field_text.size() == 0) ? 0 : $urandom_range(0, field_text.size() - 1);
        if (field_text.size() != 0 && $urandom_range(0, 1)) field_text[at] = pick_special();
        else field_text.insert(at, pick_special());
      end
    end else begin
      field_text.delete();
      repeat ($urandom_range(1, 6))
        field_text.push_back($urandom_range(0, 1) ? pick_special()
                                                  : CharWidth'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // Offer one character transaction and hold it until accepted.
  task automatic send_char(input logic [CharWidth-1:0] code, input logic real_char,
                           input logic closing);
    int unsigned gap;
    gap = feed_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_ch.char_code <= code;
    char_ch.has_char  <= real_char;
    char_ch.last_char <= closing;
    char_ch.valid     <= 1'b1;
    do @(posedge clk); while (!char_ch.ready);
    board.note_char(code, real_char, closing);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, i == s.len() - 1);
  endtask

  // Drop valid and hold off until every outstanding verdict has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    char_ch.valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Send field_text, sometimes with ignored empty items inside or as terminator.
  task automatic send_field();
    logic empty_close;
    empty_close = (field_text.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (field_text[i]) begin
      if ($urandom_range(0, 19) == 0)
        send_char(CharWidth'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_char(field_text[i], 1'b1, !empty_close && i == field_text.size() - 1);
    end
    if (empty_close) send_char(CharWidth'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at random, check every verdict transaction.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    verdict_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      gap = drain_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        verdict_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      verdict_ch.ready <= 1'b1;
      do @(posedge clk); while (!verdict_ch.valid);
      board.check_verdict(verdict_ch.is_valid);
      if ($urandom_range(0, 11) == 0) drain_calm = !drain_calm;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned field_no;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    char_ch.has_char  = 1'b0;
    char_ch.last_char = 1'b0;
    rst_n             = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed fields
    send_char(8'h00, 1'b0, 1'b1);        // empty field
    send_text("+");                      // bare sign counts as valid
    send_text(".");                      // bare point counts as valid
    send_text("-.5e-9");                 // signed mantissa and exponent
    send_text("1 E 2");                  // blanks around the exponent letter
    send_text("1e");                     // exponent without digits
    send_text("\t");                     // whitespace only
    send_text("9x");                     // stray character
    send_char(8'hFF, 1'b1, 1'b1);        // top character code
    send_char(CHAR_ZERO + 8'd7, 1'b1, 1'b0);
    send_char(8'hFF, 1'b0, 1'b1);        // close on an empty item, code ignored

    // hold off once with everything drained
    hold_until_drained();

    field_no = 0;
    while (chars_sent < CharTarget) begin
      compose_field();
      send_field();
      field_no++;
      if (field_no == 40 || $urandom_range(0, 49) == 0) hold_until_drained();
      if ($urandom_range(0, 11) == 0) feed_calm = !feed_calm;
    end

    hold_until_drained();
    repeat (SettleCycles) @(posedge clk);
    if (board.mismatches == 0 && board.verdicts_due.size() == 0)
      $display("number_literal_validator_test OK");
    else
      $display("number_literal_validator_test NOT OK");
    $finish;
  end

endmodule
